>>> hw/rtl/lbph_pkg.sv
// ----------------------------------------------------------------------------
// lbph_pkg
// Types and constants shared by the LBP histogram block.
// ----------------------------------------------------------------------------
package lbph_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int BIN_COUNT  = 256;
    localparam int COUNT_BITS = 22;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int BIN_BITS   = $clog2(BIN_COUNT);
    localparam int CFG_BITS   = 11;
    localparam int CFG_IDX_BITS = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_BITS  = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLANES = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic       op;
        logic [7:0] pixel;
        logic [7:0] bin_index;
    } t_in_item;

    typedef struct packed {
        logic                  code_valid;
        logic [7:0]            lbp_code;
        logic [COUNT_BITS-1:0] bin_count;
        logic                  frame_done;
    } t_out_item;

    // Classified work handed from front to back.
    typedef struct packed {
        logic       op;
        logic       clear;
        logic       code_valid;
        logic [7:0] code;
        logic       frame_done;
        logic [7:0] bin_index;
    } t_job;
endpackage

>>> hw/rtl/lbph_stream_if.sv
// ----------------------------------------------------------------------------
// lbph_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface lbph_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/lbph_ram.sv
// ----------------------------------------------------------------------------
// lbph_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end
    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/lbph_front.sv
// ----------------------------------------------------------------------------
// lbph_front
// Raster counters, line store, 3x3 window and pattern coding.
// ----------------------------------------------------------------------------
module lbph_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_take,
    input  lbph_pkg::t_in_item       i_item,
    input  logic [lbph_pkg::CFG_BITS-1:0] i_width,
    input  logic [lbph_pkg::CFG_BITS-1:0] i_height,
    input  logic [1:0]               i_planes,
    output logic                     o_job_valid,
    output lbph_pkg::t_job           o_job
);
    import lbph_pkg::*;

    // Stage 0: counters, line store address. Stage 1: window shift and code.
    logic [COL_BITS-1:0] r_col;
    logic [ROW_BITS-1:0] r_row;
    logic [1:0]          r_plane;
    logic [COL_BITS-1:0] w_last_col;
    logic [ROW_BITS-1:0] w_last_row;
    logic [1:0]          w_last_plane;
    logic [COL_BITS-1:0] w_col;
    logic [ROW_BITS-1:0] w_row;
    logic [1:0]          w_plane;
    logic                w_is_last_col, w_is_last_row, w_is_last_plane;
    logic [CFG_BITS-1:0] w_wc, w_hc;

    logic [7:0] w_ls0, w_ls1;
    logic       r_s1_valid, r_s1_op, r_s1_clear, r_s1_inner, r_s1_done;
    logic [7:0] r_s1_px, r_s1_bin;
    logic [7:0] r_win [3][3];
    logic [7:0] w_top, w_mid;
    logic [7:0] w_nb [8];
    logic [7:0] w_code;
    logic       w_pix;

    always_comb begin
        w_wc = (i_width < CFG_BITS'(3)) ? CFG_BITS'(3) :
               (i_width > CFG_BITS'(MAX_WIDTH)) ? CFG_BITS'(MAX_WIDTH) : i_width;
        w_hc = (i_height < CFG_BITS'(3)) ? CFG_BITS'(3) :
               (i_height > CFG_BITS'(MAX_HEIGHT)) ? CFG_BITS'(MAX_HEIGHT) : i_height;
        w_last_col   = COL_BITS'(w_wc - CFG_BITS'(1));
        w_last_row   = ROW_BITS'(w_hc - CFG_BITS'(1));
        w_last_plane = (i_planes == 2'd0) ? 2'd0 : i_planes - 2'd1;
        w_col   = (r_col > w_last_col) ? w_last_col : r_col;
        w_row   = (r_row > w_last_row) ? w_last_row : r_row;
        w_plane = (r_plane > w_last_plane) ? w_last_plane : r_plane;
        w_is_last_col   = (w_col == w_last_col);
        w_is_last_row   = (w_row == w_last_row);
        w_is_last_plane = (w_plane == w_last_plane);
        w_pix = i_take && (i_item.op == OP_PIXEL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_plane <= '0;
        end else if (w_pix) begin
            if (!w_is_last_col) begin
                r_col <= w_col + COL_BITS'(1);
                r_row <= w_row;
                r_plane <= w_plane;
            end else begin
                r_col <= '0;
                if (!w_is_last_row) begin
                    r_row <= w_row + ROW_BITS'(1);
                    r_plane <= w_plane;
                end else begin
                    r_row <= '0;
                    r_plane <= w_is_last_plane ? 2'd0 : w_plane + 2'd1;
                end
            end
        end
    end

    // Line stores: read now, write back in the following cycle at the same column.
    logic [COL_BITS-1:0] r_s1_col;
    lbph_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line0 (
        .i_clk(i_clk), .i_we(r_s1_valid && !r_s1_op), .i_waddr(r_s1_col),
        .i_wdata(w_mid), .i_re(w_pix), .i_raddr(w_col), .o_rdata(w_ls0));
    lbph_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line1 (
        .i_clk(i_clk), .i_we(r_s1_valid && !r_s1_op), .i_waddr(r_s1_col),
        .i_wdata(r_s1_px), .i_re(w_pix), .i_raddr(w_col), .o_rdata(w_ls1));

    // Forward a column just written when it is read right back (width limit).
    logic r_s1_fwd;
    logic [7:0] r_fwd_top, r_fwd_mid;
    always_comb begin
        w_top = r_s1_fwd ? r_fwd_top : w_ls0;
        w_mid = r_s1_fwd ? r_fwd_mid : w_ls1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else begin
            r_s1_valid <= i_take;
            r_s1_fwd   <= w_pix && r_s1_valid && !r_s1_op && (r_s1_col == w_col);
        end
        r_fwd_top  <= w_mid;
        r_fwd_mid  <= r_s1_px;
        if (i_take) begin
            r_s1_op    <= i_item.op;
            r_s1_px    <= i_item.pixel;
            r_s1_bin   <= i_item.bin_index;
            r_s1_col   <= w_col;
            r_s1_clear <= (w_col == '0) && (w_row == '0) && (w_plane == 2'd0);
            r_s1_inner <= (w_col >= COL_BITS'(2)) && (w_row >= ROW_BITS'(2));
            r_s1_done  <= w_is_last_col && w_is_last_row && w_is_last_plane;
        end
    end

    // Window after shift, coded in the same stage.
    logic [7:0] w_new [3][3];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_new[r][0] = r_win[r][1];
            w_new[r][1] = r_win[r][2];
        end
        w_new[0][2] = w_top;
        w_new[1][2] = w_mid;
        w_new[2][2] = r_s1_px;
        w_nb[0] = w_new[0][0];
        w_nb[1] = w_new[0][1];
        w_nb[2] = w_new[0][2];
        w_nb[3] = w_new[1][2];
        w_nb[4] = w_new[2][2];
        w_nb[5] = w_new[2][1];
        w_nb[6] = w_new[2][0];
        w_nb[7] = w_new[1][0];
        for (int k = 0; k < 8; k++) begin
            w_code[k] = (w_nb[k] >= w_new[1][1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (r_s1_valid && !r_s1_op) begin
            r_win <= w_new;
        end
    end

    always_comb begin
        o_job_valid      = r_s1_valid;
        o_job.op         = r_s1_op;
        o_job.clear      = !r_s1_op && r_s1_clear;
        o_job.code_valid = !r_s1_op && r_s1_inner;
        o_job.code       = (!r_s1_op && r_s1_inner) ? w_code : 8'd0;
        o_job.frame_done = !r_s1_op && r_s1_done;
        o_job.bin_index  = r_s1_bin;
    end
endmodule

>>> hw/rtl/lbph_queue.sv
// ----------------------------------------------------------------------------
// lbph_queue
// Small FIFO of classified jobs between front and back.
// ----------------------------------------------------------------------------
module lbph_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lbph_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_valid,
    output lbph_pkg::t_job o_job,
    output logic [lbph_pkg::QUEUE_BITS:0] o_level
);
    import lbph_pkg::*;

    t_job r_mem [QUEUE_DEPTH];
    logic [QUEUE_BITS-1:0] r_wp, r_rp;
    logic [QUEUE_BITS:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QUEUE_BITS'(1);
            if (i_pop)  r_rp <= r_rp + QUEUE_BITS'(1);
            r_cnt <= r_cnt + (QUEUE_BITS+1)'(i_push) - (QUEUE_BITS+1)'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign o_level = r_cnt;
endmodule

>>> hw/rtl/lbph_back.sv
// ----------------------------------------------------------------------------
// lbph_back
// Histogram update, bin read and result register.
// ----------------------------------------------------------------------------
module lbph_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  lbph_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_res_valid,
    output lbph_pkg::t_out_item o_res,
    input  logic           i_res_ready
);
    import lbph_pkg::*;

    // Bins live in RAM behind one read stage. Per-bin valid bits give the frame
    // clear and make bins never written since reset read as zero.
    logic [BIN_COUNT-1:0]  r_live;
    logic                  r_b_valid;
    t_job                  r_b_job;
    logic                  r_fwd_hit;
    logic [COUNT_BITS-1:0] r_fwd_count;
    logic                  r_res_valid;
    t_out_item             r_res;
    logic                  w_adv, w_load, w_wr;
    logic [BIN_BITS-1:0]   w_raddr, w_b_addr;
    logic [COUNT_BITS-1:0] w_rdata, w_cur, w_next;
    logic [BIN_COUNT-1:0]  w_live, w_live_next;

    assign w_adv  = r_b_valid && (!r_res_valid || i_res_ready);
    assign w_load = i_job_valid && (!r_b_valid || w_adv);
    assign o_pop  = w_load;
    assign w_wr   = w_adv && (r_b_job.op == OP_PIXEL) && r_b_job.code_valid;

    always_comb begin
        w_raddr  = (i_job.op == OP_READ) ? i_job.bin_index : i_job.code;
        w_b_addr = (r_b_job.op == OP_READ) ? r_b_job.bin_index : r_b_job.code;
        w_live   = r_b_job.clear ? '0 : r_live;
        // Take the count written by the job just ahead when it hit the same bin.
        if (r_fwd_hit) begin
            w_cur = r_fwd_count;
        end else if (w_live[w_b_addr]) begin
            w_cur = w_rdata;
        end else begin
            w_cur = '0;
        end
        w_next = (w_cur == COUNT_MAX) ? w_cur : w_cur + COUNT_BITS'(1);
        w_live_next = w_live;
        if (r_b_job.code_valid) begin
            w_live_next[w_b_addr] = 1'b1;
        end
    end

    lbph_ram #(.WIDTH(COUNT_BITS), .DEPTH(BIN_COUNT)) u_bins (
        .i_clk(i_clk), .i_we(w_wr), .i_waddr(w_b_addr), .i_wdata(w_next),
        .i_re(w_load), .i_raddr(w_raddr), .o_rdata(w_rdata));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
            r_b_valid <= 1'b0;
            r_fwd_hit <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_b_valid <= 1'b1;
                r_fwd_hit <= w_wr && (w_raddr == w_b_addr);
            end else if (w_adv) begin
                r_b_valid <= 1'b0;
            end
            if (w_adv && r_b_job.op == OP_PIXEL) begin
                r_live <= w_live_next;
            end
            if (w_adv) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
        if (w_load) begin
            r_b_job     <= i_job;
            r_fwd_count <= w_next;
        end
        if (w_adv) begin
            r_res.code_valid <= r_b_job.code_valid;
            r_res.lbp_code   <= r_b_job.code;
            r_res.bin_count  <= (r_b_job.op == OP_READ) ? w_cur : '0;
            r_res.frame_done <= r_b_job.frame_done;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
endmodule

>>> hw/rtl/lbp_code_histogram.sv
// ----------------------------------------------------------------------------
// lbp_code_histogram
// 3x3 local binary pattern coder with a saturating 256-bin code histogram.
// ----------------------------------------------------------------------------
// One item per clock is taken while the front accepts, and one result per
// item is returned, in order. Each item passes the window stage, the queue,
// the histogram read and the result register. The front accepts while the
// queue has room for every item still in its stage; the back drains one job
// per cycle when the output is free.
// Configuration should be written while idle; it does not reset the counters.
module lbp_code_histogram (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [lbph_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [lbph_pkg::CFG_BITS-1:0]     i_cfg_data,
    lbph_stream_if.sink   s_in,
    lbph_stream_if.source m_out
);
    import lbph_pkg::*;

    logic [CFG_BITS-1:0] r_width, r_height;
    logic [1:0]          r_planes;
    logic                w_take, w_job_valid, w_q_valid, w_pop;
    t_job                w_job, w_q_job;
    logic [QUEUE_BITS:0] w_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_BITS'(640);
            r_height <= CFG_BITS'(480);
            r_planes <= 2'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_PLANES: r_planes <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Room for this item plus the one in the window stage.
    assign s_in.ready = (w_level <= (QUEUE_BITS+1)'(QUEUE_DEPTH - 2));
    assign w_take     = s_in.valid && s_in.ready;

    lbph_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(w_take), .i_item(s_in.data),
        .i_width(r_width), .i_height(r_height), .i_planes(r_planes),
        .o_job_valid(w_job_valid), .o_job(w_job));

    lbph_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_job_valid), .i_job(w_job),
        .i_pop(w_pop), .o_valid(w_q_valid), .o_job(w_q_job), .o_level(w_level));

    lbph_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(w_q_valid), .i_job(w_q_job),
        .o_pop(w_pop), .o_res_valid(m_out.valid), .o_res(m_out.data),
        .i_res_ready(m_out.ready));
endmodule
